// ===== design/kcp_pkg.sv =====
// Shared types for the k-closest-points selector.
`timescale 1ns / 1ps

package kcp_pkg;

  // Sort key: squared distance, then x and y with the sign bit flipped
  localparam int KEY_W   = 64;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 32;

  typedef logic [KEY_W-1:0] kcp_key_t;

  // What one cell hands to its upper neighbor
  typedef struct packed {
    kcp_key_t entry;
    logic     gt;
  } kcp_link_t;

  // Point leaving the key pipeline
  typedef struct packed {
    logic     valid;
    logic     last;
    kcp_key_t key;
  } kcp_stage_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } kcp_state_t;

endpackage

// ===== design/kcp_key.sv =====
// Two-stage pipeline that turns a point into its sort key.
`timescale 1ns / 1ps

module kcp_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [kcp_pkg::COORD_W-1:0] in_x,
  input  logic [kcp_pkg::COORD_W-1:0] in_y,
  input  logic                        in_last,
  output kcp_pkg::kcp_stage_t         out,
  output logic                        last_pend
);
  import kcp_pkg::*;

  logic                      v1;
  logic                      last1;
  logic [COORD_W-1:0]        x1;
  logic [COORD_W-1:0]        y1;
  logic [DIST_W-2:0]         sqx;
  logic [DIST_W-2:0]         sqy;
  logic signed [DIST_W-1:0]  prod_x;
  logic signed [DIST_W-1:0]  prod_y;
  logic [DIST_W-1:0]         sum_sq;
  logic                      v2;
  logic                      last2;
  kcp_key_t                  key2;

  // Square each coordinate; the result never exceeds 2^30
  assign prod_x = signed'(in_x) * signed'(in_x);
  assign prod_y = signed'(in_y) * signed'(in_y);

  // Sum of squares fits in 32 bits unsigned
  assign sum_sq = {1'b0, sqx} + {1'b0, sqy};

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage one: squares
  always_ff @(posedge clk) begin
    last1 <= in_last;
    x1    <= in_x;
    y1    <= in_y;
    sqx   <= prod_x[DIST_W-2:0];
    sqy   <= prod_y[DIST_W-2:0];
  end

  // Stage two: assemble key with sign-flipped coordinates
  always_ff @(posedge clk) begin
    last2 <= last1;
    key2  <= {sum_sq, x1 ^ 16'h8000, y1 ^ 16'h8000};
  end

  assign out.valid = v2;
  assign out.last  = last2;
  assign out.key   = key2;

  // A last point still travels the pipeline
  assign last_pend = (v1 && last1) || (v2 && last2);

endmodule

// ===== design/kcp_cell.sv =====
// One slot of the sorted insertion chain.
`timescale 1ns / 1ps

module kcp_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  logic                load,
  input  kcp_pkg::kcp_key_t   key,
  input  logic [CW-1:0]       fill,
  input  kcp_pkg::kcp_link_t  prev,
  output kcp_pkg::kcp_link_t  link
);
  import kcp_pkg::*;

  kcp_key_t entry;
  logic     occupied;
  logic     gt;
  logic     at_end;
  logic     take;
  kcp_key_t src;

  // Occupied slots sit below the fill level
  assign occupied = CW'(IDX) < fill;
  assign gt       = occupied && (entry > key);
  assign at_end   = CW'(IDX) == fill;
  assign take     = gt || at_end;

  // Shift up the lower neighbor's entry, or take the new key at the boundary
  assign src = prev.gt ? prev.entry : key;

  always_ff @(posedge clk) begin
    if (load && take) begin
      entry <= src;
    end
  end

  assign link.entry = entry;
  assign link.gt    = gt;

endmodule

// ===== design/kcp_top.sv =====
// k-closest-points selector: key pipeline, insertion chain and result drain.
// A point passes the key pipeline before it enters the chain; once the
// last point of a set reaches it, the state turns to drain and results are registered.
// One point per cycle within a set; results drain one word per cycle while
// m_tready is high, farthest first. After a last point, input stalls until the drain ends.
// Reset clears the kept count and drain state and sets keep_count to 1.
`timescale 1ns / 1ps

module k_closest_points_top_k_top #(
  parameter int MAX_KEEP = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: keep_count
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // Input points
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // point_x [15:0], point_y [31:16]
  input  logic        s_tlast,   // set_last
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // near_x [15:0], near_y [31:16], near_dist [63:32]
  output logic        m_tlast    // run_last
);
  import kcp_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int KW = (CW > 5) ? CW : 5;
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  logic [4:0]       keep_count;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  kcp_state_t       state;
  kcp_state_t       state_next;
  kcp_stage_t       ins;
  logic             last_pend;
  logic             in_acc;
  logic [KW-1:0]    k_wide;
  logic [KW-1:0]    max_wide;
  logic [CW-1:0]    k_eff;
  logic [CW-1:0]    c_eff;
  logic [MAX_KEEP-1:0] gt_vec;
  logic             any_gt;
  logic             ins_take;
  kcp_link_t        link [MAX_KEEP+1];
  kcp_key_t         ent [MAX_KEEP];
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    rd_idx;
  kcp_key_t         rd_ent;
  logic             out_load;
  logic             out_valid;
  logic [63:0]      out_data;
  logic             out_last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= 5'd1;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // Accept points while filling and no last point is in flight
  assign s_tready = (state == ST_FILL) && !last_pend;
  assign in_acc   = s_tvalid && s_tready;

  kcp_key u_key (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_acc),
    .in_x     (s_tdata[15:0]),
    .in_y     (s_tdata[31:16]),
    .in_last  (s_tlast),
    .out      (ins),
    .last_pend(last_pend)
  );

  // Effective k and fill level, saturated to the chain length
  assign k_wide   = KW'(keep_count);
  assign max_wide = KW'(MAX_KEEP);
  assign k_eff    = (k_wide > max_wide) ? CW'(max_wide) : CW'(k_wide);
  assign c_eff    = (count > k_eff) ? k_eff : count;

  // Insertion chain
  assign link[0].entry = '0;
  assign link[0].gt    = 1'b0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    kcp_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk (clk),
      .load(ins_take),
      .key (ins.key),
      .fill(c_eff),
      .prev(link[i]),
      .link(link[i+1])
    );
    assign gt_vec[i] = link[i+1].gt;
    assign ent[i]    = link[i+1].entry;
  end

  // Store sorted ascending, so any larger entry means the top one is larger
  assign any_gt   = |gt_vec;
  assign ins_take = ins.valid && (k_eff != '0) && ((c_eff < k_eff) || any_gt);

  // Read the farthest remaining entry
  assign cnt_m1 = count - CW'(1);
  assign rd_idx = cnt_m1[IW-1:0];
  assign rd_ent = ent[rd_idx];

  // Next state, fill level and output load
  always_comb begin
    state_next = state;
    count_next = count;
    out_load   = 1'b0;
    case (state)
      ST_FILL: begin
        if (ins.valid) begin
          count_next = (ins_take && (c_eff < k_eff)) ? c_eff + CW'(1) : c_eff;
          if (ins.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (count == '0) begin
          state_next = ST_FILL;
        end else if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          count_next = cnt_m1;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {rd_ent[63:32], rd_ent[15:0] ^ 16'h8000, rd_ent[31:16] ^ 16'h8000};
      out_last <= (count == CW'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // No point enters while results drain
  a_no_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> !s_tready)
    else $error("input accepted during drain");

  // Fill level never exceeds the chain
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEEP))
    else $error("kept count above chain length");

  // A last point reaching the chain starts the drain
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && ins.valid && ins.last) |=> state == ST_DRAIN)
    else $error("last point did not start drain");

  // The final result word leaves the store empty
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    out_load && (count == CW'(1)) |=> count == '0)
    else $error("store not cleared after final word");
`endif

endmodule
